[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// Every macro is gated off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bad_pkg.sv]
// Shared constants, types and helpers for the box-average downscaler.
// No dependencies.
package bad_pkg;

  localparam int MAX_DST_WIDTH = 256;
  localparam int MAX_SRC_SIDE  = 1024;
  localparam int MAX_FACTOR    = 16;
  localparam int SUM_W         = 16;
  localparam int DIV_STEPS     = 8;
  localparam int FAC_STEPS     = 11;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  typedef struct packed {
    logic [4:0] f;
    logic       clamped;
  } fac_t;

  typedef enum logic [3:0] {
    ST_CALC = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_RMW  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  // Zero reads as one, values above hi saturate.
  function automatic logic [10:0] clamp_side(input logic [10:0] v, input logic [10:0] hi);
    logic [10:0] r;
    r = v;
    if (v == 11'd0) r = 11'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

[sv/bad_sum_ram.sv]
// Column accumulator store: one write port, one registered read port.
// No dependencies.
module bad_sum_ram #(
  parameter int DW = 64,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/bad_factor.sv]
// Block side unit: two shift-subtract dividers for the ceiling ratios.
// Depends on bad_pkg.
module bad_factor import bad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [10:0] sw,
  input  logic [10:0] sh,
  input  logic [8:0]  dw,
  input  logic [8:0]  dh,
  output logic        done,
  output fac_t        fac
);
  logic        load_req;
  logic        busy;
  logic [3:0]  cnt;
  logic [10:0] nx, ny, qx, qy;
  logic [8:0]  rx, ry;
  logic [9:0]  tx, ty;
  logic [11:0] sx, sy;
  logic [10:0] fm;

  assign tx = {rx, nx[10]};
  assign ty = {ry, ny[10]};
  assign sx = {1'b0, sw} + {3'b0, dw} - 12'd1;
  assign sy = {1'b0, sh} + {3'b0, dh} - 12'd1;
  assign fm = (qx > qy) ? qx : qy;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst || start) begin
      load_req <= 1'b1;
      busy     <= 1'b0;
    end else if (load_req) begin
      load_req <= 1'b0;
      busy     <= 1'b1;
      cnt      <= '0;
      nx       <= sx[10:0];
      ny       <= sy[10:0];
      rx       <= '0;
      ry       <= '0;
    end else if (busy) begin
      nx <= {nx[9:0], 1'b0};
      ny <= {ny[9:0], 1'b0};
      if (tx >= {1'b0, dw}) begin
        rx <= 9'(tx - {1'b0, dw});
        qx <= {qx[9:0], 1'b1};
      end else begin
        rx <= tx[8:0];
        qx <= {qx[9:0], 1'b0};
      end
      if (ty >= {1'b0, dh}) begin
        ry <= 9'(ty - {1'b0, dh});
        qy <= {qy[9:0], 1'b1};
      end else begin
        ry <= ty[8:0];
        qy <= {qy[9:0], 1'b0};
      end
      cnt <= cnt + 4'd1;
      if (cnt == 4'(FAC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    if (fm > 11'(MAX_FACTOR)) begin
      fac.f       = 5'(MAX_FACTOR);
      fac.clamped = 1'b1;
    end else begin
      fac.f       = fm[4:0];
      fac.clamped = 1'b0;
    end
  end
endmodule

[sv/bad_avgdiv.sv]
// Four-lane divider of channel sums by pixel count, one quotient bit a cycle.
// Depends on bad_pkg.
module bad_avgdiv import bad_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] sums [4],
  input  logic [8:0]       count,
  output logic             busy,
  output logic [7:0]       quo  [4]
);
  logic [SUM_W-1:0] rem [4];
  logic [SUM_W-1:0] dsh;
  logic [2:0]       cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      dsh  <= SUM_W'({count, 7'd0});
      for (int c = 0; c < 4; c++) rem[c] <= sums[c];
    end else if (busy) begin
      for (int c = 0; c < 4; c++) begin
        if (rem[c] >= dsh) begin
          rem[c] <= rem[c] - dsh;
          quo[c] <= {quo[c][6:0], 1'b1};
        end else begin
          quo[c] <= {quo[c][6:0], 1'b0};
        end
      end
      dsh <= dsh >> 1;
      cnt <= cnt + 3'd1;
      if (cnt == 3'(DIV_STEPS - 1)) busy <= 1'b0;
    end
  end
endmodule

[sv/box_average_downscale.sv]
// Area-averaging downscaler for four-channel 8-bit pixels. Source pixels are
// taken one at a time in raster order; a pixel that lands in a covered block
// is accepted, then read-modify-writes its column accumulator in a 256-entry
// RAM; an uncovered one is only accepted. A pixel that completes a block
// starts the per-channel divide by the pixel count; s_tready stays low until
// the divide is done and the output register can take the word. After reset
// or any register write an 11-step divider recomputes the block side, with
// s_tready low through the load, the 11 steps and the hand-over. Uncovered
// destination pixels are never emitted; clear the destination store first.
module box_average_downscale import bad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // blue, green, red, alpha
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // dst_x, dst_y, out_blue, out_green, out_red,
                                 // out_alpha, scale_factor[4:0], factor_clamped, pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [10:0] sw, sh;
  logic [8:0]  dw, dh;
  state_t      state;
  fac_t        fac;
  logic        fac_done, cfg_wr, acc;
  logic [9:0]  x, y, j, i;
  logic [3:0]  xo, yo;
  logic        end_x, end_y, xo_last, yo_last, covered;
  logic [7:0]  pix [4];
  logic        first, emit;
  logic [7:0]  ej, ei;
  logic [8:0]  count;
  logic [63:0] rdata, wdata;
  logic [SUM_W-1:0] nsum [4];
  logic        div_start, div_busy;
  logic [7:0]  quo [4];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= 11'd1; sh <= 11'd1; dw <= 9'd1; dh <= 9'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SRC_W: sw <= clamp_side(pwdata[10:0], 11'(MAX_SRC_SIDE));
        REG_SRC_H: sh <= clamp_side(pwdata[10:0], 11'(MAX_SRC_SIDE));
        REG_DST_W: dw <= 9'(clamp_side({2'b0, pwdata[8:0]}, 11'(MAX_DST_WIDTH)));
        REG_DST_H: dh <= 9'(clamp_side({2'b0, pwdata[8:0]}, 11'h1FF));
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SRC_W: prdata = {21'd0, sw};
      REG_SRC_H: prdata = {21'd0, sh};
      REG_DST_W: prdata = {23'd0, dw};
      REG_DST_H: prdata = {23'd0, dh};
      default:   prdata = '0;
    endcase
  end

  bad_factor u_fac (
    .clk, .rst, .start(cfg_wr), .sw, .sh, .dw, .dh, .done(fac_done), .fac
  );

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign end_x    = ({1'b0, x} + 11'd1) == sw;
  assign end_y    = ({1'b0, y} + 11'd1) == sh;
  assign xo_last  = {1'b0, xo} == (fac.f - 5'd1);
  assign yo_last  = {1'b0, yo} == (fac.f - 5'd1);
  assign covered  = (j < {1'b0, dw}) && (i < {1'b0, dh});

  // Walk the source position and its block coordinates without dividing.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      x <= '0; y <= '0; j <= '0; i <= '0; xo <= '0; yo <= '0;
    end else if (acc) begin
      if (end_x) begin
        x <= '0; xo <= '0; j <= '0;
        if (end_y) begin
          y <= '0; yo <= '0; i <= '0;
        end else begin
          y <= y + 10'd1;
          if (yo_last) begin
            yo <= '0;
            i  <= i + 10'd1;
          end else begin
            yo <= yo + 4'd1;
          end
        end
      end else begin
        x <= x + 10'd1;
        if (xo_last) begin
          xo <= '0;
          j  <= j + 10'd1;
        end else begin
          xo <= xo + 4'd1;
        end
      end
    end
  end

  // Latch the word and the block context at accept.
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int c = 0; c < 4; c++) pix[c] <= s_tdata[8*c +: 8];
      first <= (xo == 4'd0) && (yo == 4'd0);
      emit  <= (xo_last || end_x) && (yo_last || end_y);
      ej    <= j[7:0];
      ei    <= i[7:0];
      count <= ({5'd0, xo} + 9'd1) * ({5'd0, yo} + 9'd1);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      nsum[c] = first ? {8'd0, pix[c]} : rdata[SUM_W*c +: SUM_W] + {8'd0, pix[c]};
      wdata[SUM_W*c +: SUM_W] = nsum[c];
    end
  end

  bad_sum_ram #(.DW(64), .AW(8)) u_ram (
    .clk, .raddr(j[7:0]), .rdata, .we(state == ST_RMW), .waddr(ej), .wdata
  );

  assign div_start = (state == ST_RMW) && emit;

  bad_avgdiv u_div (
    .clk, .rst, .start(div_start), .sums(nsum), .count, .busy(div_busy), .quo
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      state <= ST_CALC;
    end else begin
      unique case (state)
        ST_CALC: if (fac_done) state <= ST_IDLE;
        ST_IDLE: if (acc && covered) state <= ST_RMW;
        ST_RMW:  state <= emit ? ST_DIV : ST_IDLE;
        ST_DIV:  if (!div_busy && (!m_tvalid || m_tready)) state <= ST_IDLE;
        default: state <= ST_CALC;
      endcase
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DIV && !div_busy && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {2'b0, fac.clamped, fac.f, quo[3], quo[2], quo[1], quo[0], ei, ej};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
endmodule

[sv/bad_checker.sv]
// Port-level checks for the downscaler, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module bad_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);
  `ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "word dropped while stalled")
  `ASSERT_IMP(a_fac_range, m_tvalid, m_tdata[52:48] != 5'd0 && m_tdata[52:48] <= 5'd16, "bad block side")
  `ASSERT_IMP(a_clamp, m_tvalid && m_tdata[53], m_tdata[52:48] == 5'd16, "clamp flag without clamp")
  `ASSERT_NXT(a_cfg_stall, psel && penable && pwrite, !s_tready, "input open during side recompute")
endmodule

bind box_average_downscale bad_checker u_chk (.*);

[bench/tb.sv]
// Self-checking bench for box_average_downscale: streams source pixels, predicts averaged output.
// Depends on bad_pkg and the box_average_downscale RTL; APB writes set the image sizes.
module tb;
  import bad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMEOUT_CYCLES = 1500000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int ITEM_TARGET    = 1250;

  typedef struct {
    bit [7:0] x;
    bit [7:0] y;
    bit [7:0] ch[4];
    bit [4:0] f;
    bit       clamped;
  } avg_pixel_t;

  class downscale_scoreboard;
    bit [10:0]   src_w, src_h;
    bit [8:0]    dst_w, dst_h;
    int unsigned col, row;
    int unsigned col_sums[MAX_DST_WIDTH][4];
    avg_pixel_t  expected_pixels[$];
    int          errors;

    function void clear();
      src_w = 1; src_h = 1; dst_w = 1; dst_h = 1;
      col = 0; row = 0; errors = 0;
      expected_pixels.delete();
    endfunction

    function int unsigned limit_side(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_size(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_SRC_W: src_w = 11'(limit_side(val[10:0], MAX_SRC_SIDE));
        REG_SRC_H: src_h = 11'(limit_side(val[10:0], MAX_SRC_SIDE));
        REG_DST_W: dst_w = 9'(limit_side(val[8:0], MAX_DST_WIDTH));
        REG_DST_H: dst_h = 9'(limit_side(val[8:0], 511));
      endcase
      col = 0;
      row = 0;
    endfunction

    function void note_pixel(logic [31:0] d);
      int unsigned fx, fy, f, j, i, x0, y0, x1, y1;
      bit          clamped;
      avg_pixel_t  e;
      fx = (src_w + dst_w - 1) / dst_w;
      fy = (src_h + dst_h - 1) / dst_h;
      f = (fx > fy) ? fx : fy;
      clamped = 0;
      if (f > MAX_FACTOR) begin
        f = MAX_FACTOR;
        clamped = 1;
      end
      j = col / f;
      i = row / f;
      if (j < dst_w && i < dst_h) begin
        x0 = j * f;
        y0 = i * f;
        x1 = (x0 + f < src_w) ? x0 + f : src_w;
        y1 = (y0 + f < src_h) ? y0 + f : src_h;
        for (int c = 0; c < 4; c++) begin
          if (col == x0 && row == y0) col_sums[j][c] = 32'(d[8*c +: 8]);
          else col_sums[j][c] += 32'(d[8*c +: 8]);
        end
        if (col + 1 == x1 && row + 1 == y1) begin
          e.x = j[7:0];
          e.y = i[7:0];
          for (int c = 0; c < 4; c++)
            e.ch[c] = 8'(col_sums[j][c] / ((x1 - x0) * (y1 - y0)));
          e.f = f[4:0];
          e.clamped = clamped;
          expected_pixels.push_back(e);
        end
      end
      col++;
      if (col >= src_w) begin
        col = 0;
        row++;
        if (row >= src_h) row = 0;
      end
    endfunction

    function void mismatch(string what, int unsigned exp_v, int unsigned act_v);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(logic [55:0] d);
      avg_pixel_t e;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, d);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (d[7:0] !== e.x) mismatch("dst_x", e.x, d[7:0]);
      if (d[15:8] !== e.y) mismatch("dst_y", e.y, d[15:8]);
      for (int c = 0; c < 4; c++)
        if (d[16+8*c +: 8] !== e.ch[c]) mismatch($sformatf("channel %0d", c), e.ch[c],
                                                 d[16+8*c +: 8]);
      if (d[52:48] !== e.f) mismatch("scale_factor", e.f, d[52:48]);
      if (d[53] !== e.clamped) mismatch("factor_clamped", e.clamped, d[53]);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // blue, green, red, alpha
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;        // dst_x, dst_y, blue, green, red, alpha, factor[4:0], clamped
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  downscale_scoreboard sb = new();
  int  cycle_count = 0;
  int  pixels_sent = 0;
  bit  steady_flow = 0;   // no idling on either side while set, unless hold_request holds the receiver off
  bit  hold_request = 0;

  box_average_downscale i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // Receiver: short random stalls, the odd long one, and a long hold on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 0;
        repeat (400) @(posedge clk);
        hold_request = 0;
      end else if (steady_flow) begin
        m_tready <= 1;
      end else if ($urandom_range(0, 40) == 0) begin
        m_tready <= 0;
        n = $urandom_range(20, 60);
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_word(input logic [31:0] d);
    int gap;
    gap = 0;
    if (!steady_flow)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    // Sample tready mid-cycle; it is stable up to the next rising edge.
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
    pixels_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    forever begin
      @(negedge clk);
      if (sb.pending() == 0) break;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_size(idx, val);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_sizes(input int sw, input int sh, input int dw, input int dh);
    write_size(REG_SRC_W, sw);
    write_size(REG_SRC_H, sh);
    write_size(REG_DST_W, dw);
    write_size(REG_DST_H, dh);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_word($urandom);
  endtask

  initial begin
    int sw, sh, dw, dh, n, kind;
    sb.clear();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset sizes: one pixel per frame, every pixel emits.
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    drain();
    // Zero sizes read as one.
    set_sizes(0, 0, 0, 0);
    send_word(32'h00FF_00FF);
    send_word(32'hFF00_FF00);
    drain();
    // Clipped blocks at the right and bottom edges.
    set_sizes(3, 3, 2, 2);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h0101_0101);
    send_word(32'hFEFE_FEFE);
    send_word(32'h8080_8080);
    send_word(32'h7F7F_7F7F);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    drain();
    // Oversized registers saturate; no block completes here.
    set_sizes(2047, 2047, 511, 300);
    send_random(4);
    drain();
    // Factor too large: clamp.
    set_sizes(20, 1, 1, 1);
    send_word(32'hFFFF_FFFF);
    send_random(4);
    drain();

    // Widest destination row, reaching the highest column; hold the receiver
    // off at the start so the input stalls behind a full output.
    set_sizes(256, 1, 256, 1);
    hold_request = 1;
    steady_flow = 1;
    send_random(256);
    steady_flow = 0;
    drain();

    kind = 0;
    while (pixels_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        sw = $urandom_range(17, 60); sh = $urandom_range(1, 20);
        dw = $urandom_range(1, 3);   dh = $urandom_range(1, 3);
      end else begin
        sw = $urandom_range(1, 24);  sh = $urandom_range(1, 24);
        dw = $urandom_range(1, 12);  dh = $urandom_range(1, 12);
      end
      set_sizes(sw, sh, dw, dh);
      steady_flow = ($urandom_range(0, 5) == 0);
      if (kind == 1 && !hold_request) hold_request = 1;
      n = sw * sh;
      if (n > 200) n = 200;
      else if ($urandom_range(0, 3) == 0) n += $urandom_range(1, sw);
      send_random(n);
      steady_flow = 0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/bad_pkg.sv
sv/bad_sum_ram.sv
sv/bad_factor.sv
sv/bad_avgdiv.sv
sv/box_average_downscale.sv
sv/bad_checker.sv
bench/tb.sv
